@@ rtl/acld_pkg.sv @@
`default_nettype none

package acld_pkg;

  // default sizing
  localparam int ACLD_LINE_MAX  = 128;
  localparam int ACLD_FIELD_CAP = 12;

  // result command codes
  localparam logic [3:0] CMD_HELLO       = 4'd0;
  localparam logic [3:0] CMD_PING        = 4'd1;
  localparam logic [3:0] CMD_BUZZER      = 4'd2;
  localparam logic [3:0] CMD_ESTOP       = 4'd3;
  localparam logic [3:0] CMD_ESTOP_CLEAR = 4'd4;
  localparam logic [3:0] CMD_START       = 4'd5;
  localparam logic [3:0] CMD_STOP        = 4'd6;
  localparam logic [3:0] CMD_UNKNOWN     = 4'd7;
  localparam logic [3:0] CMD_OVERRUN     = 4'd8;

  // result error codes
  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_BAD_NUMBER = 3'd1;
  localparam logic [2:0] ERR_BAD_SIDE   = 3'd2;
  localparam logic [2:0] ERR_BAD_FORMAT = 3'd3;
  localparam logic [2:0] ERR_OVERFLOW   = 3'd4;

  // keyword identifiers, grouped by field
  localparam logic [3:0] KW_HELLO       = 4'd0;
  localparam logic [3:0] KW_PING        = 4'd1;
  localparam logic [3:0] KW_CMD         = 4'd2;
  localparam logic [3:0] KW_BUZZER      = 4'd3;
  localparam logic [3:0] KW_ESTOP       = 4'd4;
  localparam logic [3:0] KW_ESTOP_CLEAR = 4'd5;
  localparam logic [3:0] KW_START       = 4'd6;
  localparam logic [3:0] KW_STOP        = 4'd7;
  localparam logic [3:0] KW_LEFT        = 4'd8;
  localparam logic [3:0] KW_RIGHT       = 4'd9;

  // characters of interest
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_A_LO   = 8'h61;
  localparam logic [7:0] CH_Z_LO   = 8'h7A;

  // longest keyword, in characters
  localparam int KW_MAX_LEN = 11;

  typedef struct packed {
    logic [3:0]  command;
    logic [2:0]  error_code;
    logic [31:0] number;
    logic        side;
  } res_t;

  function automatic logic [7:0] to_upper(input logic [7:0] c);
    logic [7:0] u;
    if (c >= CH_A_LO && c <= CH_Z_LO) begin
      u = c - 8'd32;
    end else begin
      u = c;
    end
    return u;
  endfunction

  function automatic logic [6:0] kw_len(input logic [3:0] id);
    logic [6:0] n;
    case (id)
      KW_HELLO:       n = 7'd5;
      KW_PING:        n = 7'd4;
      KW_CMD:         n = 7'd3;
      KW_BUZZER:      n = 7'd6;
      KW_ESTOP:       n = 7'd5;
      KW_ESTOP_CLEAR: n = 7'd11;
      KW_START:       n = 7'd5;
      KW_STOP:        n = 7'd4;
      KW_LEFT:        n = 7'd4;
      KW_RIGHT:       n = 7'd5;
      default:        n = 7'd0;
    endcase
    return n;
  endfunction

  // expected character at a position, nul past the end of the keyword
  function automatic logic [7:0] kw_char(input logic [3:0] id, input logic [6:0] pos);
    logic [8*KW_MAX_LEN-1:0] txt;
    logic [7:0]              ch;
    case (id)
      KW_HELLO:       txt = {"HELLO", 48'h0};
      KW_PING:        txt = {"PING", 56'h0};
      KW_CMD:         txt = {"CMD", 64'h0};
      KW_BUZZER:      txt = {"BUZZER", 40'h0};
      KW_ESTOP:       txt = {"ESTOP", 48'h0};
      KW_ESTOP_CLEAR: txt = {"RESET_", "ESTOP"};
      KW_START:       txt = {"START", 48'h0};
      KW_STOP:        txt = {"STOP", 56'h0};
      KW_LEFT:        txt = {"LEFT", 56'h0};
      KW_RIGHT:       txt = {"RIGHT", 48'h0};
      default:        txt = '0;
    endcase
    if (pos < 7'(KW_MAX_LEN)) begin
      ch = txt[8*(KW_MAX_LEN-1-int'(pos[3:0])) +: 8];
    end else begin
      ch = CH_NUL;
    end
    return ch;
  endfunction

endpackage

`default_nettype wire

@@ rtl/ascii_command_line_decoder.sv @@
`default_nettype none

// Incremental decoder for '$'-prefixed, comma-separated, case-insensitive
// command lines arriving one received byte per transfer (in_kind 0) or as a
// receive overrun event (in_kind 1). The line is never stored: per field only
// keyword match flags, a character count and number accumulators are kept. A CR
// or LF ends a line and gives at most one result transfer (command, error code,
// number, side); empty or over-long lines, lines not starting with '$', unknown
// heads and bare PING or CMD heads give nothing, and an overrun event always
// gives an overrun result. One byte is taken every clock cycle while in_ready
// is high: each byte goes through a single layer of match and accumulate logic
// into the line state, and its result lands in the output register or, while
// that is stalled, in a second result register (skid stage) that lets the input
// keep flowing for one result; in_ready falls only when two results are waiting.
module ascii_command_line_decoder #(
  parameter int LINE_MAX  = acld_pkg::ACLD_LINE_MAX,
  parameter int FIELD_CAP = acld_pkg::ACLD_FIELD_CAP
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_kind,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [3:0]       out_command,
  output logic [2:0]       out_error_code,
  output logic [31:0]      out_number,
  output logic             out_side
);

  import acld_pkg::*;

  localparam int LEN_W = $clog2(LINE_MAX);
  localparam int FN_W  = $clog2(FIELD_CAP);

  // line state
  logic [LEN_W-1:0] len_r, len_nxt;
  logic             is_cmd_r, is_cmd_nxt;
  logic [FN_W-1:0]  fn_r, fn_nxt;
  logic [6:0]       cif_r, cif_nxt;
  logic [2:0]       head_r, head_nxt;
  logic [4:0]       verb_r, verb_nxt;
  logic [1:0]       side_r, side_nxt;
  logic [31:0]      ping_r, ping_nxt;
  logic [8:0]       small_r, small_nxt;
  logic             small_ok_r, small_ok_nxt;
  logic             ping_open_r, ping_open_nxt;
  logic             nul_r, nul_nxt;

  // result registers: output stage plus skid stage
  logic out_valid_r, out_valid_nxt;
  logic skid_valid_r, skid_valid_nxt;
  res_t out_r, out_nxt;
  res_t skid_r, skid_nxt;

  logic       in_xfer;
  logic [7:0] up_c;
  logic       is_digit;
  logic [3:0] dig;
  logic       do_clear;
  logic       res_vld;
  res_t       res;

  // per-byte match and accumulate terms
  logic [2:0]  head_fed, head_cls, head_fin;
  logic [4:0]  verb_fed, verb_cls, verb_fin;
  logic [1:0]  side_fed, side_cls, side_fin;
  logic [35:0] ping_mul;
  logic [11:0] small_mul;
  logic        num_ok;
  logic        line_vld;
  res_t        line_res;

  assign in_ready = !skid_valid_r;
  assign in_xfer  = in_valid && in_ready;

  assign up_c     = to_upper(in_rx_byte);
  assign is_digit = (in_rx_byte >= CH_ZERO) && (in_rx_byte <= CH_NINE);
  // low nibble of an ascii digit is its value
  assign dig      = in_rx_byte[3:0];

  // keyword flags fed with this byte, and closed at the current field length
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      head_fed[k] = head_r[k] && (up_c == kw_char(4'(KW_HELLO + k), cif_r));
      head_cls[k] = head_r[k] && (cif_r == kw_len(4'(KW_HELLO + k)));
    end
    for (int k = 0; k < 5; k++) begin
      verb_fed[k] = verb_r[k] && (up_c == kw_char(4'(KW_BUZZER + k), cif_r));
      verb_cls[k] = verb_r[k] && (cif_r == kw_len(4'(KW_BUZZER + k)));
    end
    for (int k = 0; k < 2; k++) begin
      side_fed[k] = side_r[k] && (up_c == kw_char(4'(KW_LEFT + k), cif_r));
      side_cls[k] = side_r[k] && (cif_r == kw_len(4'(KW_LEFT + k)));
    end
  end

  // times ten plus digit, as shifts and adds
  assign ping_mul  = ({4'b0, ping_r} << 3) + ({4'b0, ping_r} << 1) + 36'(dig);
  assign small_mul = ({3'b0, small_r} << 3) + ({3'b0, small_r} << 1) + 12'(dig);

  // line resolution at CR/LF: close the open field, then pick the command
  always_comb begin
    head_fin = (fn_r == FN_W'(0)) ? head_cls : head_r;
    verb_fin = (fn_r == FN_W'(1)) ? verb_cls : verb_r;
    side_fin = (fn_r == FN_W'(3)) ? side_cls : side_r;
    num_ok   = small_ok_r && !small_r[8];
    line_res = '0;
    line_vld = 1'b1;
    if (head_fin[0]) begin
      line_res.command = CMD_HELLO;
    end else if (head_fin[1] && fn_r != '0) begin
      line_res.command = CMD_PING;
      line_res.number  = ping_r;
    end else if (!head_fin[2] || fn_r == '0) begin
      // unknown head, bare PING, or CMD without a verb
      line_vld = 1'b0;
    end else if (verb_fin[0] && fn_r >= FN_W'(2)) begin
      line_res.command = CMD_BUZZER;
      if (num_ok) begin
        line_res.number = 32'(small_r);
      end else begin
        line_res.error_code = ERR_BAD_NUMBER;
      end
    end else if (verb_fin[1]) begin
      line_res.command = CMD_ESTOP;
    end else if (verb_fin[2]) begin
      line_res.command = CMD_ESTOP_CLEAR;
    end else if (verb_fin[3] && fn_r >= FN_W'(2)) begin
      line_res.command = CMD_START;
      if (num_ok) begin
        line_res.number = 32'(small_r);
      end else begin
        line_res.error_code = ERR_BAD_NUMBER;
      end
    end else if (verb_fin[4] && fn_r >= FN_W'(3)) begin
      line_res.command = CMD_STOP;
      if (!num_ok) begin
        line_res.error_code = ERR_BAD_NUMBER;
      end else begin
        line_res.number = 32'(small_r);
        if (side_fin[0]) begin
          line_res.side = 1'b0;
        end else if (side_fin[1]) begin
          line_res.side = 1'b1;
        end else begin
          line_res.error_code = ERR_BAD_SIDE;
        end
      end
    end else begin
      line_res.command    = CMD_UNKNOWN;
      line_res.error_code = ERR_BAD_FORMAT;
    end
  end

  // line state update for one accepted transfer
  always_comb begin
    len_nxt       = len_r;
    is_cmd_nxt    = is_cmd_r;
    fn_nxt        = fn_r;
    cif_nxt       = cif_r;
    head_nxt      = head_r;
    verb_nxt      = verb_r;
    side_nxt      = side_r;
    ping_nxt      = ping_r;
    small_nxt     = small_r;
    small_ok_nxt  = small_ok_r;
    ping_open_nxt = ping_open_r;
    nul_nxt       = nul_r;
    do_clear      = 1'b0;
    res_vld       = 1'b0;
    res           = '0;

    if (in_xfer) begin
      if (in_kind) begin
        // overrun event: drop the line and report
        do_clear       = 1'b1;
        res_vld        = 1'b1;
        res.command    = CMD_OVERRUN;
        res.error_code = ERR_OVERFLOW;
      end else if (in_rx_byte == CH_CR || in_rx_byte == CH_LF) begin
        if (len_r != '0) begin
          do_clear = 1'b1;
          res_vld  = is_cmd_r && line_vld;
          res      = line_res;
        end
      end else if (len_r == LEN_W'(LINE_MAX - 1)) begin
        // over-long line, this byte is dropped too
        do_clear = 1'b1;
      end else begin
        len_nxt = len_r + LEN_W'(1);
        if (len_r == '0) begin
          is_cmd_nxt = (in_rx_byte == CH_DOLLAR);
        end else if (is_cmd_r && !nul_r) begin
          if (in_rx_byte == CH_NUL) begin
            nul_nxt = 1'b1;
          end else if (in_rx_byte == CH_COMMA && fn_r < FN_W'(FIELD_CAP - 1)) begin
            // close the field and open the next one
            if (fn_r == FN_W'(0)) begin
              head_nxt      = head_cls;
              ping_open_nxt = 1'b1;
            end else if (fn_r == FN_W'(1)) begin
              verb_nxt = verb_cls;
            end else if (fn_r == FN_W'(3)) begin
              side_nxt = side_cls;
            end
            fn_nxt  = fn_r + FN_W'(1);
            cif_nxt = '0;
          end else begin
            if (fn_r == FN_W'(0)) begin
              head_nxt = head_fed;
            end else if (fn_r == FN_W'(1)) begin
              verb_nxt = verb_fed;
              if (ping_open_r) begin
                if (!is_digit) begin
                  ping_open_nxt = 1'b0;
                end else if (ping_mul[35:32] != '0) begin
                  ping_nxt = '1;
                end else begin
                  ping_nxt = ping_mul[31:0];
                end
              end
            end else if (fn_r == FN_W'(2)) begin
              if (is_digit) begin
                if (cif_r == '0) begin
                  small_ok_nxt = 1'b1;
                end
                // saturate at one past the legal range
                small_nxt = (small_mul > 12'd255) ? 9'd256 : small_mul[8:0];
              end else begin
                small_ok_nxt = 1'b0;
              end
            end else if (fn_r == FN_W'(3)) begin
              side_nxt = side_fed;
            end
            if (cif_r != 7'd127) begin
              cif_nxt = cif_r + 7'd1;
            end
          end
        end
      end
    end

    if (do_clear) begin
      len_nxt       = '0;
      is_cmd_nxt    = 1'b0;
      fn_nxt        = '0;
      cif_nxt       = '0;
      head_nxt      = '1;
      verb_nxt      = '1;
      side_nxt      = '1;
      ping_nxt      = '0;
      small_nxt     = '0;
      small_ok_nxt  = 1'b0;
      ping_open_nxt = 1'b0;
      nul_nxt       = 1'b0;
    end
  end

  // output and skid stage steering
  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    if (out_valid_r && out_ready) begin
      if (skid_valid_r) begin
        out_nxt        = skid_r;
        skid_valid_nxt = 1'b0;
      end else if (res_vld) begin
        out_nxt = res;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end else if (!out_valid_r) begin
      if (res_vld) begin
        out_nxt       = res;
        out_valid_nxt = 1'b1;
      end
    end else if (res_vld) begin
      // output stalled: park the new result
      skid_nxt       = res;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r        <= '0;
      is_cmd_r     <= 1'b0;
      fn_r         <= '0;
      cif_r        <= '0;
      head_r       <= '1;
      verb_r       <= '1;
      side_r       <= '1;
      ping_r       <= '0;
      small_r      <= '0;
      small_ok_r   <= 1'b0;
      ping_open_r  <= 1'b0;
      nul_r        <= 1'b0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      len_r        <= len_nxt;
      is_cmd_r     <= is_cmd_nxt;
      fn_r         <= fn_nxt;
      cif_r        <= cif_nxt;
      head_r       <= head_nxt;
      verb_r       <= verb_nxt;
      side_r       <= side_nxt;
      ping_r       <= ping_nxt;
      small_r      <= small_nxt;
      small_ok_r   <= small_ok_nxt;
      ping_open_r  <= ping_open_nxt;
      nul_r        <= nul_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_command    = out_r.command;
  assign out_error_code = out_r.error_code;
  assign out_number     = out_r.number;
  assign out_side       = out_r.side;

endmodule

`default_nettype wire

@@ rtl/acld_checker.sv @@
`default_nettype none

module acld_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        in_kind,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [3:0]  out_command,
  input wire logic [2:0]  out_error_code,
  input wire logic [31:0] out_number,
  input wire logic        out_side
);

  import acld_pkg::*;

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // after an overrun transfer, out_valid is always high in the next cycle
  a_overrun_reported: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_kind |=> out_valid)
    else $error("overrun event not reported");

  a_overrun_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_command == CMD_OVERRUN |->
      out_error_code == ERR_OVERFLOW && out_number == '0 && !out_side)
    else $error("overrun result carries wrong fields");

  a_bad_format: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error_code == ERR_BAD_FORMAT |->
      out_command == CMD_UNKNOWN && out_number == '0 && !out_side)
    else $error("bad format result carries wrong fields");

endmodule

bind ascii_command_line_decoder acld_checker u_acld_checker (.*);

`default_nettype wire
